// ===== design/tasr_pkg.sv =====
`default_nettype none

package tasr_pkg;

  // Storage and geometry.
  localparam int OUT_DEPTH   = 1024;
  localparam int MAX_DIMS    = 4;
  localparam int NUM_SIZES   = 4;
  localparam int ADDR_W      = $clog2(OUT_DEPTH);
  localparam int CNT_W       = $clog2(OUT_DEPTH + 1);
  localparam int DIM_W       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int SIZE_W      = 16;
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_MASK  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ELEM_TYPE  = 3'd6;

  // Request opcodes.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_CONFIG = 3'd1;
  localparam logic [2:0] ST_RANGE      = 3'd2;
  localparam logic [2:0] ST_INCOMPLETE = 3'd3;
  localparam logic [2:0] ST_EXTRA      = 3'd4;

  // Element types.
  localparam logic [1:0] ET_INT32 = 2'd0;
  localparam logic [1:0] ET_INT16 = 2'd1;
  localparam logic [1:0] ET_INT8  = 2'd2;
  localparam logic [1:0] ET_UINT8 = 2'd3;

  // Commands passed from the front end to the back end.
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_REPLY = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] value;
    logic [9:0]               read_index;
  } tasr_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sum_value;
    logic [2:0]               status;
  } tasr_res_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] value;
    logic [2:0]        status;
  } tasr_cmd_t;

  typedef struct packed {
    logic sweeping;
    logic add_busy;
  } tasr_back_stat_t;

endpackage

`default_nettype wire

// ===== design/tasr_front.sv =====
`default_nettype none

module tasr_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  tasr_pkg::tasr_req_t             req,
  input  logic                            cfg_we,
  input  logic [tasr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tasr_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            ready,
  output logic                            restart,
  output logic [1:0]                      elem_type,
  output logic                            push,
  output tasr_pkg::tasr_cmd_t             cmd
);
  import tasr_pkg::*;

  localparam logic S_SETUP = 1'b0;
  localparam logic S_RUN   = 1'b1;

  logic                state;
  logic [DIM_W-1:0]    step;
  logic [2:0]          num_dims;
  logic [SIZE_W-1:0]   dim_size [NUM_SIZES];
  logic [3:0]          axis_mask;
  logic [CNT_W-1:0]    prod;
  logic                ovf;
  logic [CNT_W-1:0]    stride [MAX_DIMS];
  logic [SIZE_W-1:0]   coord [MAX_DIMS];
  logic [ADDR_W-1:0]   addr;
  logic                all_received;
  logic                excess_seen;

  logic [MAX_DIMS-1:0] dim_used;
  logic [MAX_DIMS-1:0] kept;
  logic [MAX_DIMS-1:0] reduced;
  logic                zero_size;
  logic                ok;
  logic [CNT_W+SIZE_W-1:0] mult;
  logic                found;
  logic [DIM_W-1:0]    sel;
  logic [SIZE_W-1:0]   coord_next [MAX_DIMS];
  logic [ADDR_W-1:0]   addr_next;

  assign restart   = cfg_we && (cfg_index <= REG_ELEM_TYPE);
  assign ready     = (state == S_RUN);
  assign mult      = (CNT_W + SIZE_W)'(prod) * (CNT_W + SIZE_W)'(dim_size[step]);

  // Setup classification. The kept dimensions set the output shape; the
  // product of kept extents (prod) is built up by the setup sequencer.
  always_comb begin
    int kept_cnt;
    zero_size = 1'b0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      dim_used[d] = (int'(num_dims) > d);
      kept[d]     = dim_used[d] && !axis_mask[d];
      reduced[d]  = dim_used[d] && axis_mask[d];
      if (dim_used[d] && (dim_size[d] == '0)) begin
        zero_size = 1'b1;
      end
    end
    kept_cnt = $countones(kept);
    ok = (num_dims != 3'd0) && (int'(num_dims) <= MAX_DIMS) && (reduced != '0) &&
         !zero_size && !ovf && (kept_cnt == 1 || kept_cnt == 2 || kept_cnt == 4);
  end

  // Row-major coordinate advance. The innermost dimension that can still
  // count up is incremented and all inner ones wrap. Since the inner kept
  // extents multiply up to the stride, the output address moves by one when
  // the incremented dimension is kept, and falls back by stride - 1 when it
  // is reduced.
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (dim_used[d] && ({1'b0, coord[d]} + 17'd1 < {1'b0, dim_size[d]})) begin
        found = 1'b1;
        sel   = DIM_W'(d);
      end
    end
    for (int e = 0; e < MAX_DIMS; e++) begin
      if (!found || e > int'(sel)) begin
        coord_next[e] = '0;
      end else if (e == int'(sel)) begin
        coord_next[e] = coord[e] + SIZE_W'(1);
      end else begin
        coord_next[e] = coord[e];
      end
    end
    if (!found) begin
      addr_next = '0;
    end else if (kept[sel]) begin
      addr_next = addr + ADDR_W'(1);
    end else begin
      addr_next = addr + ADDR_W'(1) - stride[sel][ADDR_W-1:0];
    end
  end

  // Classification of an accepted request into a back-end command.
  always_comb begin
    push       = 1'b0;
    cmd.kind   = CMD_ADD;
    cmd.addr   = addr;
    cmd.value  = req.value;
    cmd.status = ST_OK;
    if (accept) begin
      unique case (req.op)
        OP_ADD: begin
          push = ok && !all_received;
        end
        OP_READ: begin
          push = 1'b1;
          if (!ok) begin
            cmd.kind   = CMD_REPLY;
            cmd.status = ST_BAD_CONFIG;
          end else if ((32'(req.read_index) >= 32'(prod)) ||
                       (32'(req.read_index) >= 32'(OUT_DEPTH))) begin
            cmd.kind   = CMD_REPLY;
            cmd.status = ST_RANGE;
          end else begin
            cmd.kind   = CMD_READ;
            cmd.addr   = ADDR_W'(req.read_index);
            cmd.status = excess_seen ? ST_EXTRA : (all_received ? ST_OK : ST_INCOMPLETE);
          end
        end
        OP_CLEAR: begin
          push     = 1'b1;
          cmd.kind = CMD_CLEAR;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SETUP;
      step         <= DIM_W'(MAX_DIMS - 1);
      prod         <= CNT_W'(1);
      ovf          <= 1'b0;
      num_dims     <= 3'd4;
      for (int i = 0; i < NUM_SIZES; i++) begin
        dim_size[i] <= SIZE_W'(1);
      end
      axis_mask    <= '0;
      elem_type    <= ET_INT32;
      for (int d = 0; d < MAX_DIMS; d++) begin
        coord[d] <= '0;
      end
      addr         <= '0;
      all_received <= 1'b0;
      excess_seen  <= 1'b0;
    end else if (restart) begin
      unique case (cfg_index)
        REG_NUM_DIMS:   num_dims    <= cfg_data[2:0];
        REG_DIM_SIZE_0: dim_size[0] <= cfg_data;
        REG_DIM_SIZE_1: dim_size[1] <= cfg_data;
        REG_DIM_SIZE_2: dim_size[2] <= cfg_data;
        REG_DIM_SIZE_3: dim_size[3] <= cfg_data;
        REG_AXIS_MASK:  axis_mask   <= cfg_data[3:0];
        REG_ELEM_TYPE:  elem_type   <= cfg_data[1:0];
        default: begin
        end
      endcase
      state        <= S_SETUP;
      step         <= DIM_W'(MAX_DIMS - 1);
      prod         <= CNT_W'(1);
      ovf          <= 1'b0;
      for (int d = 0; d < MAX_DIMS; d++) begin
        coord[d] <= '0;
      end
      addr         <= '0;
      all_received <= 1'b0;
      excess_seen  <= 1'b0;
    end else if (state == S_SETUP) begin
      // One dimension per cycle, innermost first.
      if (dim_used[step]) begin
        stride[step] <= prod;
        if (kept[step]) begin
          if (mult > (CNT_W + SIZE_W)'(OUT_DEPTH)) begin
            ovf <= 1'b1;
          end else begin
            prod <= CNT_W'(mult);
          end
        end
      end
      if (step == '0) begin
        state <= S_RUN;
      end else begin
        step <= step - DIM_W'(1);
      end
    end else if (accept) begin
      unique case (req.op)
        OP_ADD: begin
          if (ok) begin
            if (all_received) begin
              excess_seen <= 1'b1;
            end else begin
              for (int d = 0; d < MAX_DIMS; d++) begin
                coord[d] <= coord_next[d];
              end
              addr         <= addr_next;
              all_received <= !found;
            end
          end
        end
        OP_CLEAR: begin
          for (int d = 0; d < MAX_DIMS; d++) begin
            coord[d] <= '0;
          end
          addr         <= '0;
          all_received <= 1'b0;
          excess_seen  <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/tasr_queue.sv =====
`default_nettype none

module tasr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tasr_pkg::tasr_cmd_t push_data,
  input  logic                pop,
  output tasr_pkg::tasr_cmd_t head,
  output logic                empty,
  output logic                full
);
  import tasr_pkg::*;

  tasr_cmd_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QCNT_W-1:0] count;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/tasr_back.sv =====
`default_nettype none

module tasr_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      restart,
  input  logic [1:0]                elem_type,
  input  logic                      q_empty,
  input  tasr_pkg::tasr_cmd_t       q_head,
  output logic                      pop,
  output logic                      done,
  output tasr_pkg::tasr_res_t       res,
  output tasr_pkg::tasr_back_stat_t stat
);
  import tasr_pkg::*;

  logic [DATA_W-1:0] mem [OUT_DEPTH];
  logic              sweeping;
  logic [ADDR_W-1:0] sweep_addr;
  logic              s1_valid;
  tasr_cmd_t         s1;
  logic [DATA_W-1:0] rd_data;
  logic              w_valid;
  logic [ADDR_W-1:0] w_addr;
  logic [DATA_W-1:0] w_data;

  logic              s1_add;
  logic [DATA_W-1:0] operand;
  logic [DATA_W-1:0] sum;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  function automatic logic [DATA_W-1:0] wrap_elem(input logic [1:0] et,
                                                  input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    unique case (et)
      ET_INT16: r = {{(DATA_W - 16){v[15]}}, v[15:0]};
      ET_INT8:  r = {{(DATA_W - 8){v[7]}}, v[7:0]};
      ET_UINT8: r = {{(DATA_W - 8){1'b0}}, v[7:0]};
      default:  r = v;
    endcase
    return r;
  endfunction

  assign pop    = !q_empty && !sweeping;
  assign s1_add = s1_valid && (s1.kind == CMD_ADD);

  // The add that wrote at the edge where this entry was read is forwarded.
  assign operand = (w_valid && (w_addr == s1.addr)) ? w_data : rd_data;
  assign sum     = operand + s1.value;

  assign mem_we    = sweeping || s1_add;
  assign mem_waddr = sweeping ? sweep_addr : s1.addr;
  assign mem_wdata = sweeping ? '0 : sum;

  assign stat.sweeping = sweeping;
  assign stat.add_busy = s1_add;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[q_head.addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
      s1_valid   <= 1'b0;
      w_valid    <= 1'b0;
      done       <= 1'b0;
    end else begin
      if (restart) begin
        sweeping   <= 1'b1;
        sweep_addr <= '0;
      end else if (sweeping) begin
        if (sweep_addr == ADDR_W'(OUT_DEPTH - 1)) begin
          sweeping   <= 1'b0;
          sweep_addr <= '0;
        end else begin
          sweep_addr <= sweep_addr + ADDR_W'(1);
        end
      end else if (pop && (q_head.kind == CMD_CLEAR)) begin
        sweeping   <= 1'b1;
        sweep_addr <= '0;
      end
      s1_valid <= pop && (q_head.kind != CMD_CLEAR);
      w_valid  <= s1_add;
      done     <= s1_valid && ((s1.kind == CMD_READ) || (s1.kind == CMD_REPLY));
    end
  end

  always_ff @(posedge clk) begin
    s1            <= q_head;
    w_addr        <= s1.addr;
    w_data        <= sum;
    res.sum_value <= (s1.kind == CMD_READ) ? wrap_elem(elem_type, operand) : '0;
    res.status    <= s1.status;
  end

endmodule

`default_nettype wire

// ===== design/tensor_axis_sum_reduce_top.sv =====
// Axis sum reduction of a streamed row-major integer tensor of up to four
// dimensions into a 1024-entry accumulator memory.
// Requests enter on req when start is high and busy is low. An add request
// carries the next element in row-major order; a read request returns one
// output entry with a status; a clear request zeroes the sums and restarts
// the element stream. Each read produces exactly one result: done is high
// for one cycle with res valid, and the receiver cannot stall it.
// A read request passes through the command queue, the s1 stage register
// and the res register. Throughput: one request per cycle while busy is
// low. The accumulator memory has a write port and a separate read port,
// and forwards a sum still being written to the next access of the entry.
// A clear sweeps the memory one entry per cycle; busy is high from the start
// of the sweep to its end. Requests behind a clear wait in the four-entry
// command queue.
// Reset, and any write to a defined configuration register, starts such a
// sweep and a setup pass that derives the output shape and address strides;
// busy is high meanwhile. The user must write configuration through cfg_we,
// cfg_index and cfg_data only while idle; the block does not enforce it.
`default_nettype none

module tensor_axis_sum_reduce_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  tasr_pkg::tasr_req_t             req,
  output logic                            done,
  output tasr_pkg::tasr_res_t             res,
  input  logic                            cfg_we,
  input  logic [tasr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tasr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tasr_pkg::*;

  logic            accept;
  logic            fr_ready;
  logic            fr_restart;
  logic [1:0]      elem_type;
  logic            q_push;
  tasr_cmd_t       q_in;
  logic            q_pop;
  tasr_cmd_t       q_head;
  logic            q_empty;
  logic            q_full;
  tasr_back_stat_t stat;

  // The front end takes a request whenever its setup is done, the queue has
  // room and no sweep is running.
  assign busy   = !fr_ready || q_full || stat.sweeping;
  assign accept = start && !busy;

  tasr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ready     (fr_ready),
    .restart   (fr_restart),
    .elem_type (elem_type),
    .push      (q_push),
    .cmd       (q_in)
  );

  tasr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  tasr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .restart   (fr_restart),
    .elem_type (elem_type),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (q_pop),
    .done      (done),
    .res       (res),
    .stat      (stat)
  );

  // A command is never pushed into a full queue.
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  // A configuration restart always starts a memory sweep.
  a_restart_sweep: assert property (@(posedge clk) disable iff (rst)
    fr_restart |=> (stat.sweeping && busy))
    else $error("restart did not start a clearing sweep");

  // The sweep and an accumulate never compete for the write port.
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    stat.sweeping |-> !stat.add_busy)
    else $error("sweep and accumulate write in the same cycle");

endmodule

`default_nettype wire

// ===== tb/tensor_axis_sum_reduce_top_tb.sv =====
// Self-checking bench for the axis sum reduction block.
//
// Requests are produced by the main initial block as a queue of pending
// requests. A clocked driver presents them on the falling edge and holds each
// one until the block takes it (start high and busy low at a rising edge). A
// clocked monitor watches the same rising edges. It updates a private model of
// the accumulators whenever a request or a register write is taken, queues the
// result expected from every read, and checks each done strobe against the
// oldest queued result.
//
// The run starts with a few requests against the reset setup, which reduces
// no axis and so must be rejected. A short directed phase follows, and then
// four phases with the largest extents. The rest is random phases, mostly
// valid shapes with small extents. Those streams are complete, with random
// content, some noise, extra elements and restarts followed by a cut-short stream.
module tensor_axis_sum_reduce_top_tb;
  import tasr_pkg::*;

  localparam int ITEM_TARGET   = 1350;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 5000000;
  localparam int MAX_REPORTS   = 10;

  // Opcode 3 is not defined by the block and must be ignored.
  localparam logic [1:0] OP_NONE = 2'd3;
  // Register index 7 decodes to no register; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic      hold;
    tasr_req_t item;
  } pending_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  start     = 1'b0;
  tasr_req_t             req       = '0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  busy;
  logic                  done;
  tasr_res_t             res;

  tensor_axis_sum_reduce_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Shared between the stimulus, the driver and the monitor.
  pending_t  pending_requests [$];
  tasr_res_t expected_sums [$];
  bit        req_taken   = 1'b0;
  int        idle_pct    = 9;
  int        fail_count  = 0;
  int        cycle_count = 0;

  // Private model of the block: the register copies and the accumulator state.
  logic [2:0]        m_num_dims;
  logic [3:0][15:0]  m_size;
  logic [3:0]        m_mask;
  logic [1:0]        m_etype;
  logic [31:0]       m_acc [OUT_DEPTH];
  logic [3:0][15:0]  m_coord;
  bit                m_all_in;
  bit                m_extra;

  // The stimulus side keeps its own view of the current shape.
  bit                g_ok      = 1'b0;
  int unsigned       g_entries = 0;
  longint unsigned   g_total   = 0;
  int                items_made = 0;

  // A setup is usable when the dimension count is 1 to 4 and at least one used
  // axis is reduced. Every used extent must be nonzero, one, two or four axes
  // must be kept, and the kept extents must fit in the accumulator store. Mask
  // bits at or above the dimension count play no part.
  function automatic bit shape_valid(input logic [2:0] nd, input logic [3:0][15:0] sz,
                                     input logic [3:0] mask, output int unsigned entries);
    int unsigned     kept;
    longint unsigned n;
    logic [3:0]      used;
    entries = 0;
    kept    = 0;
    n       = 1;
    if (nd < 3'd1 || nd > 3'(MAX_DIMS)) return 1'b0;
    used = mask & ((4'd1 << nd) - 4'd1);
    if (used == 4'd0) return 1'b0;
    for (int d = 0; d < int'(nd); d++) begin
      if (sz[d] == 16'd0) return 1'b0;
      if (!used[d]) begin
        kept++;
        n = n * sz[d];
        if (n > OUT_DEPTH) return 1'b0;
      end
    end
    if (kept != 1 && kept != 2 && kept != 4) return 1'b0;
    entries = int'(n);
    return 1'b1;
  endfunction

  // Sums wrap modulo 2^32 while they build up. The narrow element types only
  // take effect on read, by truncation and then sign or zero extension.
  function automatic logic [31:0] wrap_to_type(input logic [31:0] v, input logic [1:0] et);
    case (et)
      ET_INT16: return {{16{v[15]}}, v[15:0]};
      ET_INT8:  return {{24{v[7]}}, v[7:0]};
      ET_UINT8: return {24'd0, v[7:0]};
      default:  return v;
    endcase
  endfunction

  function automatic void restart_sums();
    for (int i = 0; i < OUT_DEPTH; i++) m_acc[i] = '0;
    m_coord  = '0;
    m_all_in = 1'b0;
    m_extra  = 1'b0;
  endfunction

  function automatic void model_reset();
    m_num_dims = 3'd4;
    m_size     = {4{16'd1}};
    m_mask     = 4'd0;
    m_etype    = ET_INT32;
    restart_sums();
  endfunction

  // A write to any defined register restarts the stream as a clear does.
  function automatic void model_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_NUM_DIMS:   m_num_dims = data[2:0];
      REG_DIM_SIZE_0: m_size[0]  = data;
      REG_DIM_SIZE_1: m_size[1]  = data;
      REG_DIM_SIZE_2: m_size[2]  = data;
      REG_DIM_SIZE_3: m_size[3]  = data;
      REG_AXIS_MASK:  m_mask     = data[3:0];
      REG_ELEM_TYPE:  m_etype    = data[1:0];
      default:        return;
    endcase
    restart_sums();
  endfunction

  function automatic void model_request(input tasr_req_t r);
    int unsigned entries;
    int unsigned addr;
    bit          ok;
    bit          wrapped;
    logic [3:0]  used;
    tasr_res_t   out;
    ok = shape_valid(m_num_dims, m_size, m_mask, entries);
    case (r.op)
      OP_ADD: begin
        if (ok && m_all_in) begin
          // Elements past the end of the tensor are dropped but remembered.
          m_extra = 1'b1;
        end else if (ok) begin
          used = m_mask & ((4'd1 << m_num_dims) - 4'd1);
          addr = 0;
          for (int d = 0; d < int'(m_num_dims); d++)
            if (!used[d]) addr = addr * m_size[d] + m_coord[d];
          m_acc[addr] = m_acc[addr] + r.value;
          // Step the row-major coordinates, innermost first.
          wrapped = 1'b1;
          for (int d = int'(m_num_dims) - 1; d >= 0; d--) begin
            if (wrapped) begin
              if (int'(m_coord[d]) + 1 < int'(m_size[d])) begin
                m_coord[d] = m_coord[d] + 16'd1;
                wrapped    = 1'b0;
              end else begin
                m_coord[d] = 16'd0;
              end
            end
          end
          if (wrapped) m_all_in = 1'b1;
        end
      end
      OP_READ: begin
        out.sum_value = '0;
        if (!ok) begin
          out.status = ST_BAD_CONFIG;
        end else if (r.read_index >= entries) begin
          out.status = ST_RANGE;
        end else begin
          out.sum_value = wrap_to_type(m_acc[r.read_index], m_etype);
          out.status    = m_extra ? ST_EXTRA : (m_all_in ? ST_OK : ST_INCOMPLETE);
        end
        expected_sums = {expected_sums, out};
      end
      OP_CLEAR: restart_sums();
      default: ;
    endcase
  endfunction

  // The driver presents the head of the pending queue on the falling edge and
  // keeps it there until the block takes it. A hold marker at the head stops
  // the flow until every read issued so far has returned. On idle cycles the
  // request bus carries noise, which the block must ignore while start is low.
  always @(negedge clk) begin : drive
    logic      go;
    tasr_req_t nxt;
    go  = start && !req_taken;
    nxt = req;
    if (!go && pending_requests.size() != 0 && pending_requests[0].hold &&
        expected_sums.size() == 0)
      pending_requests.delete(0);
    if (!go) begin
      if (!rst && pending_requests.size() != 0 && !pending_requests[0].hold &&
          $urandom_range(99) >= idle_pct) begin
        nxt = pending_requests[0].item;
        pending_requests.delete(0);
        go  = 1'b1;
      end else begin
        nxt.op         = 2'($urandom);
        nxt.value      = $urandom;
        nxt.read_index = 10'($urandom);
      end
    end
    start <= go;
    req   <= nxt;
  end

  // The monitor checks results before it applies what is taken at the same
  // edge. A read's result never comes at the edge that takes the read.
  always @(posedge clk) begin : observe
    tasr_res_t want;
    if (rst) begin
      model_reset();
      req_taken = 1'b0;
    end else begin
      if (done) begin
        if (expected_sums.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected read result: sum %0d status %0d",
                     res.sum_value, res.status);
        end else begin
          want = expected_sums.pop_front();
          if (res.sum_value !== want.sum_value || res.status !== want.status) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("read mismatch: expected sum %0d status %0d, got sum %0d status %0d",
                       want.sum_value, want.status, res.sum_value, res.status);
          end
        end
      end
      if (cfg_we) model_register(cfg_index, cfg_data);
      req_taken = start && !busy;
      if (req_taken) model_request(req);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Adds under a rejected setup and the undefined opcode do nothing, so they
  // do not count toward the amount of stimulus.
  task automatic push_req(input logic [1:0] op, input logic [31:0] val,
                          input logic [9:0] idx);
    pending_t p;
    p.hold            = 1'b0;
    p.item.op         = op;
    p.item.value      = val;
    p.item.read_index = idx;
    pending_requests = {pending_requests, p};
    if (op != OP_NONE && (op != OP_ADD || g_ok)) items_made++;
  endtask

  task automatic push_add(input logic [31:0] val);
    push_req(OP_ADD, val, 10'($urandom));
  endtask

  task automatic push_read(input logic [9:0] idx);
    push_req(OP_READ, $urandom, idx);
  endtask

  task automatic push_hold();
    pending_t p;
    p      = '0;
    p.hold = 1'b1;
    pending_requests = {pending_requests, p};
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(11))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0080;
      4:       return 32'h0000_00FF;
      5:       return 32'h0000_7FFF;
      6:       return 32'h0000_8000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly entries that exist, sometimes anywhere in the 10-bit range.
  function automatic logic [9:0] rand_read_index();
    if (g_entries != 0 && $urandom_range(99) < 85)
      return 10'($urandom_range(g_entries - 1));
    return 10'($urandom);
  endfunction

  // Waits until every request has been taken and every read has returned.
  // It then lets the pipeline settle and waits out any sweep still running.
  // The whole check repeats, since the driver may launch the last request at
  // the very edge where the queue was seen empty.
  task automatic drain();
    do begin
      while (pending_requests.size() != 0 || start || expected_sums.size() != 0)
        @(negedge clk);
      repeat (SETTLE_CYCLES) @(negedge clk);
      while (busy) @(negedge clk);
    end while (pending_requests.size() != 0 || start || expected_sums.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  // Writes all registers once the block is quiet. The bits above each narrow
  // register's width carry noise that the block must drop.
  task automatic configure(input logic [2:0] nd, input logic [15:0] s0,
                           input logic [15:0] s1, input logic [15:0] s2,
                           input logic [15:0] s3, input logic [3:0] mask,
                           input logic [1:0] et);
    logic [3:0][15:0] sz;
    sz = {s3, s2, s1, s0};
    drain();
    write_reg(REG_NUM_DIMS,   {13'($urandom), nd});
    write_reg(REG_DIM_SIZE_0, s0);
    write_reg(REG_DIM_SIZE_1, s1);
    write_reg(REG_DIM_SIZE_2, s2);
    write_reg(REG_DIM_SIZE_3, s3);
    write_reg(REG_AXIS_MASK,  {12'($urandom), mask});
    write_reg(REG_ELEM_TYPE,  {14'($urandom), et});
    g_ok    = shape_valid(nd, sz, mask, g_entries);
    g_total = 1;
    for (int d = 0; d < int'(nd) && d < MAX_DIMS; d++) g_total = g_total * sz[d];
  endtask

  // Picks a random setup. Most are valid with small extents. The rest break
  // one rule each: the dimension count, a zero extent, nothing reduced, three
  // kept axes, or too many output entries.
  task automatic pick_setup();
    logic [2:0]       nd;
    logic [3:0][15:0] sz;
    logic [3:0]       mask;
    int unsigned      e;
    int               lim;
    if ($urandom_range(99) < 80) begin
      do begin
        nd  = 3'($urandom_range(2, 4));
        lim = (nd == 3'd4) ? 3 : 4;
        for (int d = 0; d < MAX_DIMS; d++)
          if (d < int'(nd)) sz[d] = 16'($urandom_range(1, lim));
          else sz[d] = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
        mask = 4'($urandom);
      end while (!shape_valid(nd, sz, mask, e));
    end else begin
      sz   = {4{16'd2}};
      nd   = 3'd3;
      mask = 4'b0001;
      case ($urandom_range(4))
        0: begin
          nd = 3'($urandom_range(3));
          if (nd != 3'd0) nd = nd + 3'd4;
        end
        1: sz[1] = 16'd0;
        2: begin
          nd   = 3'($urandom_range(1, 4));
          mask = 4'($urandom) & ~((4'd1 << nd) - 4'd1);
        end
        3: begin
          nd   = 3'd4;
          mask = 4'd1 << $urandom_range(3);
        end
        default: begin
          sz   = {16'd2, 16'd2, 16'd32, 16'd33};
          mask = 4'b0100;
        end
      endcase
    end
    configure(nd, sz[0], sz[1], sz[2], sz[3], mask, 2'($urandom));
  endtask

  // One stretch of elements with reads, rare undefined opcodes and now and
  // then a pause until all outstanding reads are back.
  task automatic stream(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      push_add(rand_value());
      if ($urandom_range(99) < 10) push_read(rand_read_index());
      if ($urandom_range(99) < 2) push_req(OP_NONE, $urandom, 10'($urandom));
      if (i == n / 2 && $urandom_range(1) == 1) push_hold();
    end
  endtask

  task automatic run_phase();
    int unsigned n;
    if (!g_ok) begin
      // Under a rejected setup every read must report the bad setup.
      repeat ($urandom_range(10, 20)) begin
        case ($urandom_range(5))
          0, 1:    push_add(rand_value());
          2, 3:    push_read(10'($urandom));
          4:       push_req(OP_NONE, $urandom, 10'($urandom));
          default: push_req(OP_CLEAR, $urandom, 10'($urandom));
        endcase
      end
      return;
    end
    // Small tensors are streamed in full; huge ones only in part.
    n = (g_total <= 200) ? int'(g_total) : $urandom_range(20, 60);
    stream(n);
    if (g_entries <= 32) begin
      for (int unsigned i = 0; i < g_entries; i++) push_read(10'(i));
    end else begin
      repeat (16) push_read(10'($urandom_range(g_entries - 1)));
      push_read(10'(g_entries - 1));
    end
    if (g_entries < OUT_DEPTH) push_read(10'(g_entries));
    if ($urandom_range(99) < 40) begin
      repeat ($urandom_range(1, 3)) push_add(rand_value());
      repeat (3) push_read(10'($urandom_range(g_entries - 1)));
    end
    if ($urandom_range(99) < 30) begin
      // A restart followed by a stream that is broken off early.
      push_req(OP_CLEAR, $urandom, 10'($urandom));
      stream($urandom_range(1, n));
      repeat (4) push_read(10'($urandom_range(g_entries - 1)));
    end
  endtask

  initial begin : stimulus
    int phase;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // After reset no axis is reduced, so the setup is rejected: adds are
    // ignored and reads report the bad setup with a zero sum.
    push_read(10'd0);
    push_add(32'h1234_5678);
    push_read(10'd1023);
    drain();

    // Directed phase. The shape is 2x3x2 with the middle axis summed away,
    // giving four int8 outputs. The mask bit above the dimension count and
    // the zero extent of the unused fourth axis must both be ignored.
    configure(3'd3, 16'd2, 16'd3, 16'd2, 16'd0, 4'b1010, ET_INT8);
    write_reg(REG_UNUSED, 16'($urandom));
    push_read(10'd0);
    push_add(32'h7FFF_FFFF);
    push_add(32'h8000_0000);
    push_add(32'hFFFF_FFFF);
    push_add(32'h0000_0000);
    push_add(32'h0000_007F);
    push_add(32'h0000_0080);
    push_read(10'd1);
    push_hold();
    push_add(32'h0000_00FF);
    push_add(32'h0000_7FFF);
    push_add(32'h0000_8000);
    push_add(32'h0000_0001);
    push_add($urandom);
    push_add($urandom);
    for (int i = 0; i < 4; i++) push_read(10'(i));
    // An index just past the last entry and the largest index are out of range.
    push_read(10'd4);
    push_read(10'd1023);
    // An element past the end is dropped and flagged on later reads.
    push_add(32'h0000_0055);
    push_read(10'd2);
    push_req(OP_NONE, $urandom, 10'($urandom));
    push_req(OP_CLEAR, $urandom, 10'($urandom));
    push_read(10'd0);

    // Largest extents. The first fills the whole accumulator store, the last
    // asks for one entry more than it holds.
    configure(3'd2, 16'd1024, 16'd65535, 16'd1, 16'd1, 4'b0010, ET_INT16);
    run_phase();
    configure(3'd4, 16'd3, 16'd65535, 16'd2, 16'd65535, 4'b1010, ET_UINT8);
    run_phase();
    configure(3'd4, 16'd65535, 16'd1, 16'd65535, 16'd4, 4'b0101, ET_INT32);
    run_phase();
    configure(3'd2, 16'd1025, 16'd3, 16'd7, 16'd9, 4'b0010, ET_INT8);
    run_phase();

    // Random phases. One of them runs with no idle cycles on the request side.
    phase = 0;
    while (items_made < ITEM_TARGET) begin
      pick_setup();
      idle_pct = (phase == 2) ? 0 : 9;
      run_phase();
      phase++;
    end

    drain();
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== tensor_axis_sum_reduce_top.f =====
design/tasr_pkg.sv
design/tasr_front.sv
design/tasr_queue.sv
design/tasr_back.sv
design/tensor_axis_sum_reduce_top.sv
tb/tensor_axis_sum_reduce_top_tb.sv
